// ----- rtl/core/mbps_pkg.sv -----
package mbps_pkg;

    // Depth of the byte window, and with it the longest pattern that can match.
    localparam int MAX_PATTERN = 16;

    // Pattern bytes held by the two 64-bit pattern registers.
    localparam int PATTERN_BYTES = 16;

    // Longest pattern that can actually be compared.
    localparam int MATCH_CAP = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

    // Bits of an index into the byte window.
    localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 5;
    localparam int LIMIT_W = 16;
    localparam int CFG_IW  = 3;

    localparam logic [LIMIT_W-1:0] RESULT_LIMIT_RESET = LIMIT_W'(10000);

    typedef enum logic [CFG_IW-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_RESULT_LIMIT = 3'd4
    } t_cfg_reg;

endpackage

// ----- rtl/core/masked_byte_pattern_scanner.sv -----
// Masked byte pattern scanner.
//
// The input channel carries one image byte per beat, with flags that mark the
// first byte of a segment (its base address rides along on that beat) and the
// first byte of a new search. The output channel carries one beat per match:
// the match address (segment base plus start offset), the start offset, and a
// flag that is set on the match that reaches the result limit. The
// configuration channel writes the pattern, care mask, pattern length and
// result limit; it is always ready and must only be used while the block is
// idle.
//
// Every input beat is captured in an input register. Once the output register
// is free, the compare logic updates the window and segment state and may
// load it, so a match passes through the input and output registers. The
// block takes one byte per cycle while the output side keeps up. While a
// match waits in the output register, the byte in the input register waits
// too, matching or not; once that register is full the input channel stalls
// until the receiver takes the match.
//
// Reset clears the window, the segment counters, the match count and the stop
// flag, and restores the configuration registers to zero except the result limit (10000).
module masked_byte_pattern_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mbps_pkg::DATA_W-1:0]     i_byte_value,
    input  logic                            i_first_of_segment,
    input  logic [mbps_pkg::ADDR_W-1:0]     i_segment_address,
    input  logic                            i_start_of_search,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mbps_pkg::ADDR_W-1:0]     o_match_address,
    output logic [mbps_pkg::ADDR_W-1:0]     o_match_offset,
    output logic                            o_limit_reached,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbps_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [mbps_pkg::ADDR_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [mbps_pkg::ADDR_W-1:0]        r_pat_low;
    logic [mbps_pkg::ADDR_W-1:0]        r_pat_high;
    logic [mbps_pkg::PATTERN_BYTES-1:0] r_care;
    logic [mbps_pkg::LEN_W-1:0]         r_plen;
    logic [mbps_pkg::LIMIT_W-1:0]       r_limit;

    // Input register stage.
    logic                               r_in_valid;
    logic [mbps_pkg::DATA_W-1:0]        r_in_byte;
    logic                               r_in_first;
    logic [mbps_pkg::ADDR_W-1:0]        r_in_addr;
    logic                               r_in_start;

    // Scan state. r_ptr tracks segment base plus bytes seen, so the match
    // address needs only a short subtract instead of a second wide add.
    logic [mbps_pkg::DATA_W-1:0]        r_win [mbps_pkg::MAX_PATTERN];
    logic [mbps_pkg::ADDR_W-1:0]        r_count;
    logic [mbps_pkg::ADDR_W-1:0]        r_ptr;
    logic [mbps_pkg::LIMIT_W-1:0]       r_match_count;
    logic                               r_stopped;

    // Output register.
    logic                               r_out_valid;
    logic [mbps_pkg::ADDR_W-1:0]        r_out_addr;
    logic [mbps_pkg::ADDR_W-1:0]        r_out_offset;
    logic                               r_out_limit;

    logic                               w_advance;
    logic                               w_consume;
    logic [mbps_pkg::DATA_W-1:0]        w_win [mbps_pkg::MAX_PATTERN];
    logic [2*mbps_pkg::ADDR_W-1:0]      w_pattern;
    logic [mbps_pkg::LEN_W-1:0]         w_len;
    logic [mbps_pkg::WIN_IW-1:0]        w_len_m1;
    logic [mbps_pkg::WIN_IW-1:0]        w_idx [mbps_pkg::MATCH_CAP];
    logic [mbps_pkg::MATCH_CAP-1:0]     w_byte_ok;
    logic                               w_hit;
    logic [mbps_pkg::ADDR_W-1:0]        w_count_eff;
    logic [mbps_pkg::ADDR_W-1:0]        w_ptr_eff;
    logic [mbps_pkg::LIMIT_W-1:0]       w_mc_eff;
    logic [mbps_pkg::LIMIT_W-1:0]       w_mc_inc;
    logic                               w_stopped_eff;
    logic                               w_saturated;
    logic                               w_in_segment;
    logic                               w_emit;

    assign o_cfg_ready = 1'b1;

    // The output register frees up when it is empty or its beat is taken.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_consume  = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    // Effective state after the start and first-of-segment flags.
    assign w_count_eff   = r_in_first ? '0 : r_count;
    assign w_ptr_eff     = r_in_first ? r_in_addr : r_ptr;
    assign w_mc_eff      = r_in_start ? '0 : r_match_count;
    assign w_stopped_eff = r_in_start ? 1'b0 : r_stopped;
    assign w_saturated   = (w_count_eff == '1);
    assign w_mc_inc      = w_mc_eff + 1'b1;

    // Window after the new byte shifts in; entry 0 is the newest byte.
    always_comb begin
        w_win[0] = r_in_byte;
        for (int i = 1; i < mbps_pkg::MAX_PATTERN; i++) begin
            w_win[i] = r_win[i-1];
        end
    end

    // Pattern length clipped to what the window and pattern registers hold.
    assign w_pattern = {r_pat_high, r_pat_low};
    assign w_len     = (r_plen > mbps_pkg::LEN_W'(mbps_pkg::MATCH_CAP))
                     ? mbps_pkg::LEN_W'(mbps_pkg::MATCH_CAP) : r_plen;
    assign w_len_m1  = mbps_pkg::WIN_IW'(w_len - 1'b1);

    // Pattern byte j lines up with the window entry len-1-j.
    always_comb begin
        for (int j = 0; j < mbps_pkg::MATCH_CAP; j++) begin
            w_idx[j]     = w_len_m1 - mbps_pkg::WIN_IW'(j);
            w_byte_ok[j] = !r_care[j]
                        || (mbps_pkg::LEN_W'(j) >= w_len)
                        || (w_win[w_idx[j]] == w_pattern[8*j +: 8]);
        end
    end

    assign w_hit        = &w_byte_ok;
    assign w_in_segment = (w_count_eff >= mbps_pkg::ADDR_W'(w_len_m1));
    assign w_emit       = (w_len != '0) && !w_stopped_eff && w_in_segment && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_plen     <= '0;
            r_limit    <= mbps_pkg::RESULT_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbps_pkg::REG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                mbps_pkg::REG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                mbps_pkg::REG_CARE_MASK:
                    r_care <= i_cfg_data[mbps_pkg::PATTERN_BYTES-1:0];
                mbps_pkg::REG_PATTERN_LEN:  r_plen <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_RESULT_LIMIT: r_limit <= i_cfg_data[mbps_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_first <= i_first_of_segment;
            r_in_addr  <= i_segment_address;
            r_in_start <= i_start_of_search;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
            r_count       <= '0;
            r_ptr         <= '0;
            r_match_count <= '0;
            r_stopped     <= 1'b0;
        end else if (w_consume) begin
            r_win   <= w_win;
            r_count <= w_saturated ? w_count_eff : w_count_eff + 1'b1;
            r_ptr   <= w_saturated ? w_ptr_eff : w_ptr_eff + 1'b1;
            if (w_emit) begin
                r_match_count <= w_mc_inc;
                r_stopped     <= (w_mc_inc >= r_limit);
            end else begin
                r_match_count <= w_mc_eff;
                r_stopped     <= w_stopped_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_consume && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_emit) begin
            r_out_offset <= w_count_eff - mbps_pkg::ADDR_W'(w_len_m1);
            r_out_addr   <= w_ptr_eff - mbps_pkg::ADDR_W'(w_len_m1);
            r_out_limit  <= (w_mc_inc >= r_limit);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_address = r_out_addr;
    assign o_match_offset  = r_out_offset;
    assign o_limit_reached = r_out_limit;

    // A match only appears after a byte moved out of the input register.
    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("match beat without a consumed input byte");

    // A pending match that hit the limit leaves the search stopped.
    a_limit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_limit) |-> r_stopped)
        else $error("limit reported but search not stopped");

    // A stopped search stays silent until a new search starts.
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_stopped && !r_in_start) |-> !w_emit)
        else $error("match emitted after the search stopped");

    // The segment byte count saturates rather than wrapping.
    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '1 && !(w_consume && r_in_first)) |=> (r_count == '1))
        else $error("segment byte count wrapped");

endmodule
